[design/nqse_pkg.sv]
// ----------------------------------------------------------------------------
// N-queens enumerator package
// Shared sizes, the sequencer state type and the board size clamp.
// ----------------------------------------------------------------------------
package nqse_pkg;

   localparam int MAX_BOARD  = 8;
   localparam int SIZE_W     = 4;
   localparam int COL_W      = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
   localparam int ROW_W      = $clog2(MAX_BOARD + 1);
   localparam int DIAG_N     = 2 * MAX_BOARD - 1;
   localparam int DIAG_W     = (DIAG_N > 1) ? $clog2(DIAG_N) : 1;
   localparam int FIELD_W    = 4;
   localparam int PLACE_ROWS = 8;
   localparam int PLACE_W    = FIELD_W * PLACE_ROWS;
   localparam int PLACE_USED = (MAX_BOARD < PLACE_ROWS) ? MAX_BOARD : PLACE_ROWS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

   // A size of zero counts as one; anything above the largest board is clamped.
   function automatic logic [ROW_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
      logic [ROW_W-1:0] result;
      begin
         if (size == '0) begin
            result = ROW_W'(1);
         end else if (32'(size) > MAX_BOARD) begin
            result = ROW_W'(MAX_BOARD);
         end else begin
            result = ROW_W'(size);
         end
         return result;
      end
   endfunction

endpackage

[design/n_queens_solution_enumerator_top.sv]
// ----------------------------------------------------------------------------
// N-queens solution enumerator
// Row-ordered backtracking search that hands out one solution or exhausted per request.
// ----------------------------------------------------------------------------
// Usage:
//   The request stream carries a single restart bit. A transfer with restart
//   set begins a fresh search on an empty board; a transfer with restart clear
//   continues from the last solution handed out. Each request yields exactly
//   one response transfer: either found with the queen column of every row
//   (four bits per row, row zero lowest, unused rows zero), or exhausted with
//   an all-zero placement, which repeats on every continue until a restart.
//   The board size register is written over the always ready csr channel; the user
//   must write it only while no request is outstanding; the block does not enforce it.
// Sequencing:
//   After a request transfer the search makes one step for each column trial,
//   backtrack or final out-of-columns check on the one shared conflict check
//   and queen toggle unit. The response register is loaded once the search
//   ends and the response slot is free; a continue answered exhausted at once
//   skips the search. The request side reopens in the cycle after the load,
//   so a new request is taken only once the last response is loaded.
// Reset and stalls:
//   Reset empties the board, marks no search as running, sets the board size
//   to eight and drops any pending response. A stalled receiver only holds the
//   response register; a finished search then waits until that slot frees.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_top
   import nqse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,    // [0] restart, [7:1] zero
   // Response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PLACE_W-1:0] rsp_tdata,    // [31:0] placement
   output logic [1:0]         rsp_tuser,    // [0] found, [1] exhausted
   // Board size register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_data
);

   // Sequencer and search state.
   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   board_size_ff;
   logic [COL_W-1:0]    qcol_ff [MAX_BOARD];
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    col_ff, col_in;
   logic [MAX_BOARD-1:0] cols_ff, cols_in;
   logic [DIAG_N-1:0]   down_ff, down_in;
   logic [DIAG_N-1:0]   up_ff, up_in;
   logic                finished_ff, finished_in;
   logic                found_ff, found_in;

   // Response register.
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic                rsp_exhausted_ff;
   logic [PLACE_W-1:0]  rsp_placement_ff;
   logic [PLACE_W-1:0]  placement_in;

   logic                req_fire;
   logic                restart;
   logic                cont_ok;
   logic                out_free;
   logic                load_rsp;
   logic                in_search;

   logic [ROW_W-1:0]    n;
   logic [COL_W-1:0]    trial_col;
   logic                in_range;
   logic                is_free;
   logic                last_row;
   logic [ROW_W-1:0]    pop_row;
   logic [COL_W-1:0]    pop_col;

   // Shared queen toggle unit operands and masks.
   logic                toggle_en;
   logic [ROW_W-1:0]    t_row;
   logic [COL_W-1:0]    t_col;
   logic [DIAG_W-1:0]   down_idx, up_idx;
   logic [DIAG_W-1:0]   t_down_idx, t_up_idx;

   logic                do_place;
   logic                do_skip;
   logic                do_pop;
   logic                do_exhaust;

   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign restart    = req_tdata[0];
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_placement_ff;
   assign rsp_tuser  = {rsp_exhausted_ff, rsp_found_ff};

   assign n = effective_size(board_size_ff);

   // A continue needs a running search with a row count that fits the size.
   assign cont_ok = ~finished_ff && (row_ff != '0) && (row_ff <= n);

   // Conflict check on the square under trial.
   assign trial_col = col_ff[COL_W-1:0];
   assign in_range  = col_ff < n;
   assign down_idx  = DIAG_W'(row_ff) + DIAG_W'(trial_col);
   assign up_idx    = DIAG_W'(row_ff) + DIAG_W'(MAX_BOARD - 1) - DIAG_W'(trial_col);
   assign is_free   = ~cols_ff[trial_col] & ~down_ff[down_idx] & ~up_ff[up_idx];
   assign last_row  = (row_ff + ROW_W'(1)) == n;

   // Backtrack target: the queen of the row above.
   assign pop_row = row_ff - ROW_W'(1);
   assign pop_col = qcol_ff[pop_row[COL_W-1:0]];

   // One step per cycle while searching.
   assign do_place   = in_search & in_range & is_free;
   assign do_skip    = in_search & in_range & ~is_free;
   assign do_pop     = in_search & ~in_range & (row_ff != '0);
   assign do_exhaust = in_search & ~in_range & (row_ff == '0);

   assign toggle_en  = do_place | do_pop;
   assign t_row      = do_pop ? pop_row : row_ff;
   assign t_col      = do_pop ? pop_col : trial_col;
   assign t_down_idx = DIAG_W'(t_row) + DIAG_W'(t_col);
   assign t_up_idx   = DIAG_W'(t_row) + DIAG_W'(MAX_BOARD - 1) - DIAG_W'(t_col);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (restart || cont_ok) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DELIVER;
               end
            end
         end
         ST_SEARCH: begin
            if ((do_place && last_row) || do_exhaust) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      in_search  = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_SEARCH:  in_search  = 1'b1;
         ST_DELIVER: load_rsp   = out_free;
         default: ;
      endcase
   end

   // Search datapath next values.
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      cols_in     = cols_ff;
      down_in     = down_ff;
      up_in       = up_ff;
      finished_in = finished_ff;
      found_in    = found_ff;

      if (req_fire) begin
         if (restart) begin
            row_in      = '0;
            col_in      = '0;
            cols_in     = '0;
            down_in     = '0;
            up_in       = '0;
            finished_in = 1'b0;
         end else if (cont_ok) begin
            // Starting with the column past the edge makes the first step
            // lift the last queen and resume after its column.
            col_in = n;
         end else begin
            finished_in = 1'b1;
            found_in    = 1'b0;
         end
      end

      if (toggle_en) begin
         cols_in[t_col]      = ~cols_ff[t_col];
         down_in[t_down_idx] = ~down_ff[t_down_idx];
         up_in[t_up_idx]     = ~up_ff[t_up_idx];
      end

      if (do_place) begin
         row_in = row_ff + ROW_W'(1);
         col_in = '0;
         if (last_row) begin
            found_in = 1'b1;
         end
      end

      if (do_skip) begin
         col_in = col_ff + ROW_W'(1);
      end

      if (do_pop) begin
         row_in = pop_row;
         col_in = ROW_W'(pop_col) + ROW_W'(1);
      end

      if (do_exhaust) begin
         row_in      = '0;
         cols_in     = '0;
         down_in     = '0;
         up_in       = '0;
         finished_in = 1'b1;
         found_in    = 1'b0;
      end
   end

   // Placement word from the stored queen columns, rows past the size zero.
   always_comb begin
      placement_in = '0;
      if (found_ff) begin
         for (int i = 0; i < PLACE_USED; i++) begin
            if (ROW_W'(i) < n) begin
               placement_in[FIELD_W*i +: FIELD_W] = FIELD_W'(qcol_ff[i]);
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         board_size_ff <= SIZE_W'(8);
         row_ff        <= '0;
         cols_ff       <= '0;
         down_ff       <= '0;
         up_ff         <= '0;
         finished_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         cols_ff     <= cols_in;
         down_ff     <= down_in;
         up_ff       <= up_in;
         finished_ff <= finished_in;
         if (csr_valid && csr_ready) begin
            board_size_ff <= csr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      found_ff <= found_in;
      if (do_place) begin
         qcol_ff[row_ff[COL_W-1:0]] <= trial_col;
      end
      if (load_rsp) begin
         rsp_found_ff     <= found_ff;
         rsp_exhausted_ff <= ~found_ff;
         rsp_placement_ff <= placement_in;
      end
   end

endmodule

[design/nqse_checker.sv]
// ----------------------------------------------------------------------------
// N-queens enumerator port checker
// Watches the top level ports for response and sequencing errors.
// ----------------------------------------------------------------------------
module nqse_checker
   import nqse_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic [7:0]         req_tdata,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [PLACE_W-1:0] rsp_tdata,
   input logic [1:0]         rsp_tuser,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [SIZE_W-1:0]  csr_data
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Every response is either a solution or the exhausted mark.
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] != rsp_tuser[1]))
      else $error("found and exhausted not exclusive");

   // An exhausted response has an empty placement.
   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == '0))
      else $error("exhausted response with placement");

   // A request transfer always makes the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while search running");

endmodule

bind n_queens_solution_enumerator_top nqse_checker u_nqse_checker (.*);
